// ===== src/prrt_pkg.sv =====
package prrt_pkg;

   // Header of one datagram
   typedef struct packed {
      logic [6:0]  picture_index;
      logic [7:0]  packet_index;
      logic [15:0] picture_size;
      logic [11:0] payload_length;
      logic [15:0] arrival_time;
   } req_payload_type;

   // One reported event
   typedef struct packed {
      logic        event_kind;
      logic [6:0]  out_picture;
      logic [3:0]  out_packet;
      logic [15:0] out_size;
      logic        last_of_run;
   } rsp_payload_type;

   // Fixed protocol constants
   localparam logic [15:0] CHUNK_BYTES   = 16'd2914;
   localparam int          PIC_WRAP      = 100;
   localparam int          NEWEST_LIMIT  = PIC_WRAP * 4 / 5;
   localparam int          MAX_RESULTS   = 64;

   // Packet entry status codes
   localparam logic [1:0] PKT_MISSING   = 2'd0;
   localparam logic [1:0] PKT_REQUESTED = 2'd1;
   localparam logic [1:0] PKT_HAVE      = 2'd2;

   // Event kinds
   localparam logic EV_COMPLETE = 1'b0;
   localparam logic EV_RESEND   = 1'b1;

   // Register indexes
   localparam logic REG_REORDER_DELAY   = 1'b0;
   localparam logic REG_ROUNDTRIP_DELAY = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic ptr_init;
      logic ptr_next;
      logic ptr_zero;
      logic set_start;
      logic evict;
      logic set_newest;
      logic open_clr;
      logic open_wr;
      logic open_fin;
      logic found_rd;
      logic found_wr;
      logic compl_emit;
      logic scan_first;
      logic scan_step;
      logic flush;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic match;
      logic last_cnt;
      logic last_ptr;
      logic pkt_in;
      logic free;
      logic open_ok;
      logic open_more;
      logic done_slot;
      logic scan_slot;
      logic need_emit;
      logic ent_last;
      logic emit_ready;
      logic pend_valid;
      logic out_free;
   } sts_type;

endpackage

// ===== src/prrt_ram.sv =====
module prrt_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one word, read one word registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

// ===== src/prrt_ctrl.sv =====
module prrt_ctrl import prrt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [9:0] {
      S_IDLE      = 10'b0000000001,
      S_MATCH     = 10'b0000000010,
      S_FOUND_RD  = 10'b0000000100,
      S_FOUND_CHK = 10'b0000001000,
      S_FREE      = 10'b0000010000,
      S_OPEN      = 10'b0000100000,
      S_COMPL     = 10'b0001000000,
      S_SCAN_SLOT = 10'b0010000000,
      S_SCAN_ENT  = 10'b0100000000,
      S_FLUSH     = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      scan_go;

   assign req_stall = (state_ff != S_IDLE);
   assign scan_go   = !sts.need_emit || sts.emit_ready;

   // Sequence one transaction through search, open, completion and scan
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            if (sts.match) begin
               state_in = S_FOUND_RD;
            end else if (sts.last_cnt) begin
               cmd.ptr_init = 1'b1;
               state_in     = S_FREE;
            end else begin
               cmd.ptr_next = 1'b1;
            end
         end
         S_FOUND_RD: begin
            cmd.set_start = 1'b1;
            if (sts.pkt_in) begin
               cmd.found_rd = 1'b1;
               state_in     = S_FOUND_CHK;
            end else begin
               cmd.ptr_zero = 1'b1;
               state_in     = S_COMPL;
            end
         end
         S_FOUND_CHK: begin
            cmd.found_wr = 1'b1;
            cmd.ptr_zero = 1'b1;
            state_in     = S_COMPL;
         end
         S_FREE: begin
            if (sts.free || sts.last_cnt) begin
               cmd.evict      = !sts.free;
               cmd.set_newest = 1'b1;
               if (sts.open_ok) begin
                  cmd.open_clr = 1'b1;
                  state_in     = S_OPEN;
               end else begin
                  cmd.ptr_zero = 1'b1;
                  state_in     = S_COMPL;
               end
            end else begin
               cmd.ptr_next = 1'b1;
            end
         end
         S_OPEN: begin
            if (sts.open_more) begin
               cmd.open_wr = 1'b1;
            end else begin
               cmd.open_fin = 1'b1;
               cmd.ptr_zero = 1'b1;
               state_in     = S_COMPL;
            end
         end
         S_COMPL: begin
            if (!sts.done_slot || sts.emit_ready) begin
               cmd.compl_emit = sts.done_slot;
               if (sts.last_ptr) begin
                  cmd.ptr_zero = 1'b1;
                  state_in     = S_SCAN_SLOT;
               end else begin
                  cmd.ptr_next = 1'b1;
               end
            end
         end
         S_SCAN_SLOT: begin
            if (sts.scan_slot) begin
               cmd.scan_first = 1'b1;
               state_in       = S_SCAN_ENT;
            end else if (sts.last_ptr) begin
               state_in = S_FLUSH;
            end else begin
               cmd.ptr_next = 1'b1;
            end
         end
         S_SCAN_ENT: begin
            cmd.scan_step = scan_go;
            if (scan_go && sts.ent_last) begin
               if (sts.last_ptr) begin
                  state_in = S_FLUSH;
               end else begin
                  cmd.ptr_next = 1'b1;
                  state_in     = S_SCAN_SLOT;
               end
            end
         end
         S_FLUSH: begin
            if (!sts.pend_valid) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Nothing may be held back once a transaction is finished
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !sts.pend_valid)
      else $error("pending result left while idle");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_MATCH))
      else $error("accepted transaction did not start search");

   a_flush_room: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> sts.out_free)
      else $error("flush into busy output register");

endmodule

// ===== src/prrt_datapath.sv =====
module prrt_datapath import prrt_pkg::*; #(
   parameter int SLOTS       = 4,
   parameter int MAX_PACKETS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_data,
   input  logic            csr_valid,
   input  logic            csr_index,
   input  logic [15:0]     csr_wdata,
   input  cmd_type         cmd,
   output sts_type         sts,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output rsp_payload_type rsp_data
);

   localparam int SW    = $clog2(SLOTS);
   localparam int EW    = $clog2(MAX_PACKETS + 1);
   localparam int PIW   = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
   localparam int DEPTH = SLOTS * MAX_PACKETS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [31:0] OPEN_LIMIT = 32'(MAX_PACKETS) * 32'(CHUNK_BYTES);

   function automatic logic [AW-1:0] entry_addr(input logic [SW-1:0] slot,
                                                input logic [PIW-1:0] idx);
      entry_addr = AW'(int'(slot) * MAX_PACKETS + int'(idx));
   endfunction

   req_payload_type in_ff;
   logic [15:0]     reorder_ff, roundtrip_ff;
   logic            use_ff   [SLOTS];
   logic [6:0]      pic_ff   [SLOTS];
   logic [15:0]     total_ff [SLOTS];
   logic [15:0]     recv_ff  [SLOTS];
   logic [EW-1:0]   count_ff [SLOTS];
   logic [PIW-1:0]  high_ff  [SLOTS];
   logic [SW-1:0]   start_ff, ptr_ff, cnt_ff;
   logic [6:0]      newest_ff;
   logic [EW-1:0]   ent_ff;
   logic [16:0]     off_ff;
   logic [23:0]     prod_ff;
   logic [6:0]      res_cnt_ff;
   logic            pend_valid_ff, rsp_valid_ff;
   rsp_payload_type pend_ff, rsp_ff;

   logic [SW-1:0]   ptr_inc, start_inc;
   logic            cur_use;
   logic [6:0]      cur_pic;
   logic [15:0]     cur_total, cur_recv;
   logic [EW-1:0]   cur_count;
   logic [PIW-1:0]  cur_high, pkt_pi, ent_pi;
   logic [1:0]      rd_st;
   logic [15:0]     rd_stamp, age;
   logic [8:0]      lag_raw, lag, ahead_raw, ahead;
   logic            have, need_emit, ent_last, emit, put, out_free, emit_ready;
   logic [16:0]     recv_sum;
   rsp_payload_type new_res;
   logic            ram_we;
   logic [AW-1:0]   ram_waddr, ram_raddr;
   logic [17:0]     ram_wdata, ram_rdata;

   // Read the slot under the pointer
   assign ptr_inc   = (ptr_ff == SW'(SLOTS - 1)) ? '0 : ptr_ff + 1'b1;
   assign start_inc = (start_ff == SW'(SLOTS - 1)) ? '0 : start_ff + 1'b1;
   assign cur_use   = use_ff[ptr_ff];
   assign cur_pic   = pic_ff[ptr_ff];
   assign cur_total = total_ff[ptr_ff];
   assign cur_recv  = recv_ff[ptr_ff];
   assign cur_count = count_ff[ptr_ff];
   assign cur_high  = high_ff[ptr_ff];
   assign pkt_pi    = PIW'(in_ff.packet_index);
   assign ent_pi    = ent_ff[PIW-1:0];

   // Packet entry under evaluation
   assign rd_st    = ram_rdata[17:16];
   assign rd_stamp = ram_rdata[15:0];
   assign have     = (rd_st == PKT_HAVE);
   assign age      = in_ff.arrival_time - rd_stamp;
   assign recv_sum = {1'b0, cur_recv} + 17'(in_ff.payload_length);

   // Forward distances between picture indexes, wrapped once; indexes above
   // the wrap may leave them negative
   assign lag_raw   = {2'b00, newest_ff} - {2'b00, cur_pic};
   assign lag       = lag_raw[8] ? lag_raw + 9'(PIC_WRAP) : lag_raw;
   assign ahead_raw = {2'b00, in_ff.picture_index} - {2'b00, newest_ff};
   assign ahead     = ahead_raw[8] ? ahead_raw + 9'(PIC_WRAP) : ahead_raw;

   assign need_emit = ((rd_st == PKT_MISSING) && (ent_ff < EW'(cur_high)) &&
                       (age > reorder_ff)) ||
                      ((rd_st == PKT_REQUESTED) && (age > roundtrip_ff));
   assign ent_last  = ({1'b0, ent_ff} + 1'b1) >= {1'b0, cur_count};

   // Result hand-off through pending and output registers
   assign emit       = cmd.compl_emit || (cmd.scan_step && need_emit);
   assign put        = emit && (res_cnt_ff < 7'(MAX_RESULTS));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit_ready = !pend_valid_ff || out_free || (res_cnt_ff >= 7'(MAX_RESULTS));

   always_comb begin
      new_res             = '0;
      new_res.event_kind  = cmd.compl_emit ? EV_COMPLETE : EV_RESEND;
      new_res.out_picture = cur_pic;
      new_res.out_packet  = cmd.compl_emit ? 4'd0 : 4'(ent_ff);
      new_res.out_size    = cur_total;
   end

   // Status back to the controller
   always_comb begin
      sts            = '0;
      sts.match      = cur_use && (cur_total == in_ff.picture_size) &&
                       (cur_pic == in_ff.picture_index);
      sts.last_cnt   = (cnt_ff == SW'(SLOTS - 1));
      sts.last_ptr   = (ptr_ff == SW'(SLOTS - 1));
      sts.pkt_in     = {1'b0, in_ff.packet_index} < 9'(cur_count);
      sts.free       = !cur_use;
      sts.open_ok    = (in_ff.picture_size != 16'd0) &&
                       (16'(in_ff.payload_length) <= CHUNK_BYTES) &&
                       ((25'(prod_ff) + 25'(in_ff.payload_length)) <=
                        25'(in_ff.picture_size)) &&
                       (prod_ff < 24'(in_ff.picture_size)) &&
                       (32'(in_ff.picture_size) <= OPEN_LIMIT);
      sts.open_more  = off_ff < {1'b0, in_ff.picture_size};
      sts.done_slot  = cur_use && (cur_total != 16'd0) && (cur_total == cur_recv);
      sts.scan_slot  = cur_use && ($signed(lag) <= 9'sd1);
      sts.need_emit  = need_emit;
      sts.ent_last   = ent_last;
      sts.emit_ready = emit_ready;
      sts.pend_valid = pend_valid_ff;
      sts.out_free   = out_free;
   end

   // Packet table port selection
   always_comb begin
      ram_we    = cmd.open_wr || (cmd.found_wr && !have) || (cmd.scan_step && need_emit);
      ram_waddr = cmd.found_wr ? entry_addr(ptr_ff, pkt_pi) : entry_addr(ptr_ff, ent_pi);
      if (cmd.open_wr) begin
         ram_wdata = {(9'(ent_ff) == {1'b0, in_ff.packet_index}) ? PKT_HAVE : PKT_MISSING,
                      in_ff.arrival_time};
      end else if (cmd.found_wr) begin
         ram_wdata = {PKT_HAVE, in_ff.arrival_time};
      end else begin
         ram_wdata = {PKT_REQUESTED, in_ff.arrival_time};
      end
      if (cmd.found_rd) begin
         ram_raddr = entry_addr(ptr_ff, pkt_pi);
      end else if (cmd.scan_first) begin
         ram_raddr = entry_addr(ptr_ff, '0);
      end else if (cmd.scan_step && !ent_last) begin
         ram_raddr = entry_addr(ptr_ff, ent_pi + 1'b1);
      end else begin
         ram_raddr = entry_addr(ptr_ff, ent_pi);
      end
   end

   prrt_ram #(
      .WIDTH (18),
      .DEPTH (DEPTH)
   ) u_packet_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Latch the header and precompute the packet offset
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_ff <= req_data;
      end
      prod_ff <= 24'(in_ff.packet_index) * 24'(CHUNK_BYTES);
   end

   // Hold slot table, pointers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         reorder_ff   <= 16'd10;
         roundtrip_ff <= 16'd20;
         for (int s = 0; s < SLOTS; s++) begin
            use_ff[s]   <= 1'b0;
            pic_ff[s]   <= '0;
            total_ff[s] <= '0;
            recv_ff[s]  <= '0;
            count_ff[s] <= '0;
            high_ff[s]  <= '0;
         end
         start_ff   <= '0;
         ptr_ff     <= '0;
         cnt_ff     <= '0;
         newest_ff  <= '0;
         ent_ff     <= '0;
         off_ff     <= '0;
         res_cnt_ff <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_REORDER_DELAY:   reorder_ff   <= csr_wdata;
               REG_ROUNDTRIP_DELAY: roundtrip_ff <= csr_wdata;
               default: ;
            endcase
         end

         // Walk the slot pointer
         if (cmd.load || cmd.ptr_init) begin
            ptr_ff <= start_ff;
            cnt_ff <= '0;
         end else if (cmd.ptr_next) begin
            ptr_ff <= ptr_inc;
            cnt_ff <= cnt_ff + 1'b1;
         end else if (cmd.ptr_zero) begin
            ptr_ff <= '0;
         end else if (cmd.evict) begin
            ptr_ff <= start_inc;
         end

         if (cmd.set_start) begin
            start_ff <= ptr_ff;
         end
         if (cmd.evict) begin
            start_ff          <= start_inc;
            use_ff[start_inc] <= 1'b0;
         end
         if (cmd.set_newest && ($signed(ahead) < $signed(9'(NEWEST_LIMIT)))) begin
            newest_ff <= in_ff.picture_index;
         end

         // Record a packet of a known picture
         if (cmd.found_wr && !have) begin
            recv_ff[ptr_ff] <= recv_sum[16] ? 16'hFFFF : recv_sum[15:0];
            if (in_ff.packet_index > 8'(cur_high)) begin
               high_ff[ptr_ff] <= pkt_pi;
            end
         end

         // Open a picture: sweep its entries, then fill the slot; also step the entry counter for the scan
         if (cmd.open_clr || cmd.scan_first) begin
            ent_ff <= '0;
            off_ff <= '0;
         end else if (cmd.open_wr) begin
            ent_ff <= ent_ff + 1'b1;
            off_ff <= off_ff + 17'(CHUNK_BYTES);
         end else if (cmd.scan_step && !ent_last) begin
            ent_ff <= ent_ff + 1'b1;
         end
         if (cmd.open_fin) begin
            use_ff[ptr_ff]   <= 1'b1;
            pic_ff[ptr_ff]   <= in_ff.picture_index;
            total_ff[ptr_ff] <= in_ff.picture_size;
            recv_ff[ptr_ff]  <= 16'(in_ff.payload_length);
            count_ff[ptr_ff] <= ent_ff;
            high_ff[ptr_ff]  <= pkt_pi;
         end

         // Free a completed picture
         if (cmd.compl_emit) begin
            use_ff[ptr_ff]   <= 1'b0;
            total_ff[ptr_ff] <= '0;
            recv_ff[ptr_ff]  <= '0;
            count_ff[ptr_ff] <= '0;
            high_ff[ptr_ff]  <= '0;
         end

         if (cmd.load) begin
            res_cnt_ff <= '0;
         end else if (put) begin
            res_cnt_ff <= res_cnt_ff + 1'b1;
         end
      end
   end

   // Hold one result back so the last one can be marked
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (put) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         if ((put && pend_valid_ff) || cmd.flush) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (put) begin
         pend_ff <= new_res;
      end
      if (put && pend_valid_ff) begin
         rsp_ff <= {pend_ff[$bits(rsp_payload_type)-1:1], 1'b0};
      end else if (cmd.flush) begin
         rsp_ff <= {pend_ff[$bits(rsp_payload_type)-1:1], 1'b1};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_put_room: assert property (@(posedge clock) disable iff (reset)
      (put && pend_valid_ff) |-> out_free)
      else $error("result pushed over a stalled output");

   a_start_range: assert property (@(posedge clock) disable iff (reset)
      start_ff <= SW'(SLOTS - 1))
      else $error("search start out of range");

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.open_wr |-> (ent_ff < EW'(MAX_PACKETS)))
      else $error("open sweep beyond packet limit");

endmodule

// ===== src/packet_reassembly_resend_tracker.sv =====
// Picture reassembly and resend tracker.
// req_* carries one datagram header per transaction (valid/stall). The block
// matches it to one of SLOTS picture slots, opens a new picture when needed,
// then reports finished pictures and resend requests on rsp_* (valid/stall),
// last_of_run marking the final result of each header.
// csr_* writes reorder_delay (index 0) and roundtrip_delay (index 1); it is
// always ready and should be used only while the block is idle.
// Per header: up to 2*SLOTS search steps, one cycle per packet entry
// when a picture opens, SLOTS completion checks, then a check of each slot
// and, for each slot scanned, one cycle per packet entry, set by the single
// read port of the packet table, while the scan is not held by full result
// registers. The next header is taken once the last result has moved into
// the output register.
// A stalled receiver holds the output register; the scan waits while both
// the pending and the output register are full.
// Reset (synchronous) empties all slots and restores the default delays; the
// packet table needs no clearing.
module packet_reassembly_resend_tracker import prrt_pkg::*; #(
   parameter int SLOTS       = 4,
   parameter int MAX_PACKETS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_index,
   input  logic [15:0]     csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   prrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   prrt_datapath #(
      .SLOTS       (SLOTS),
      .MAX_PACKETS (MAX_PACKETS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top import prrt_pkg::*; ();

   localparam int SLOT_NUM   = 4;
   localparam int PKT_NUM    = 16;
   localparam int CHUNK      = 2914;
   localparam int MAX_EVENTS = 64;
   localparam int SETTLE     = 300;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_data;
   logic            csr_valid;
   logic            csr_ready;
   logic            csr_index;
   logic [15:0]     csr_wdata;

   packet_reassembly_resend_tracker DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // clock generation
   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // shadow copy of the tracker state
   logic [15:0] lag_limit;
   logic [15:0] retry_limit;
   logic        pic_busy   [SLOT_NUM];
   logic [6:0]  pic_id     [SLOT_NUM];
   logic [15:0] pic_total  [SLOT_NUM];
   logic [15:0] pic_got    [SLOT_NUM];
   int          pic_pkts   [SLOT_NUM];
   int          pic_top    [SLOT_NUM];
   logic [1:0]  ent_state  [SLOT_NUM*PKT_NUM];
   logic [15:0] ent_stamp  [SLOT_NUM*PKT_NUM];
   int          hunt_from;
   logic [6:0]  latest_pic;

   rsp_payload_type expected_events[$];
   req_payload_type headers_to_send[$];

   int  mismatches;
   int  headers_sent;
   int  headers_taken;
   int  events_seen;
   int  resends_seen;
   int  completes_seen;
   int  quiet_after;
   bit  idle_on;
   bit  req_taken;
   int  req_gap;
   int  stall_left;
   int  tick;

   function automatic int wrap_gap(int older, int newer, int span);
      int d;
      d = newer - older;
      if (d < 0) d += span;
      return d;
   endfunction

   // work out the events one header causes and queue them
   function automatic void track_datagram(req_payload_type d);
      rsp_payload_type ev[$];
      rsp_payload_type tmp;
      int hit, tgt, idx, c, s, j, e, num;
      int r;
      logic [15:0] age;
      hit = -1;
      tgt = -1;
      idx = hunt_from;
      for (c = 0; c < SLOT_NUM; c++) begin
         if (hit < 0 && pic_busy[idx] && pic_total[idx] == d.picture_size &&
             pic_id[idx] == d.picture_index)
            hit = idx;
         idx = (idx + 1) % SLOT_NUM;
      end
      if (hit >= 0) begin
         // record a packet of a known picture
         if (d.packet_index < pic_pkts[hit]) begin
            e = hit * PKT_NUM + d.packet_index;
            if (ent_state[e] != PKT_HAVE) begin
               r = pic_got[hit] + d.payload_length;
               ent_stamp[e] = d.arrival_time;
               ent_state[e] = PKT_HAVE;
               pic_got[hit] = (r > 65535) ? 16'hFFFF : r[15:0];
               if (d.packet_index > pic_top[hit]) pic_top[hit] = d.packet_index;
            end
         end
         hunt_from = hit;
      end else begin
         // open a new picture, evicting when the table is full
         idx = hunt_from;
         for (c = 0; c < SLOT_NUM; c++) begin
            if (tgt < 0 && !pic_busy[idx]) tgt = idx;
            idx = (idx + 1) % SLOT_NUM;
         end
         if (tgt < 0) begin
            hunt_from = (hunt_from + 1) % SLOT_NUM;
            tgt = hunt_from;
            pic_busy[tgt] = 1'b0;
         end
         num = (int'(d.picture_size) + CHUNK - 1) / CHUNK;
         if (d.picture_size != 0 && d.payload_length <= CHUNK &&
             int'(d.packet_index) * CHUNK + int'(d.payload_length) <= int'(d.picture_size) &&
             d.packet_index < num && num <= PKT_NUM) begin
            for (j = 0; j < num; j++) begin
               ent_state[tgt*PKT_NUM+j] = PKT_MISSING;
               ent_stamp[tgt*PKT_NUM+j] = d.arrival_time;
            end
            ent_state[tgt*PKT_NUM+d.packet_index] = PKT_HAVE;
            pic_busy[tgt]  = 1'b1;
            pic_total[tgt] = d.picture_size;
            pic_got[tgt]   = 16'(d.payload_length);
            pic_pkts[tgt]  = num;
            pic_id[tgt]    = d.picture_index;
            pic_top[tgt]   = d.packet_index;
         end
         if (wrap_gap(latest_pic, d.picture_index, PIC_WRAP) < NEWEST_LIMIT)
            latest_pic = d.picture_index;
      end
      // report and free finished pictures
      for (s = 0; s < SLOT_NUM; s++) begin
         if (pic_busy[s] && pic_total[s] != 0 && pic_total[s] == pic_got[s]) begin
            tmp = '{EV_COMPLETE, pic_id[s], 4'd0, pic_total[s], 1'b0};
            if (ev.size() < MAX_EVENTS) ev = {ev, tmp};
            pic_busy[s] = 1'b0;
            pic_total[s] = '0;
            pic_got[s] = '0;
            pic_pkts[s] = 0;
            pic_top[s] = 0;
         end
      end
      // resend scan over the newest pictures
      for (s = 0; s < SLOT_NUM; s++) begin
         if (pic_busy[s] && wrap_gap(pic_id[s], latest_pic, PIC_WRAP) <= 1) begin
            for (j = 0; j < pic_pkts[s]; j++) begin
               e = s * PKT_NUM + j;
               age = d.arrival_time - ent_stamp[e];
               tmp = '{EV_RESEND, pic_id[s], j[3:0], pic_total[s], 1'b0};
               if (ent_state[e] == PKT_MISSING) begin
                  if (j < pic_top[s] && age > lag_limit) begin
                     ent_state[e] = PKT_REQUESTED;
                     ent_stamp[e] = d.arrival_time;
                     if (ev.size() < MAX_EVENTS) ev = {ev, tmp};
                  end
               end else if (ent_state[e] == PKT_REQUESTED) begin
                  if (age > retry_limit) begin
                     ent_stamp[e] = d.arrival_time;
                     if (ev.size() < MAX_EVENTS) ev = {ev, tmp};
                  end
               end
            end
         end
      end
      if (ev.size() > 0) begin
         tmp = ev[ev.size()-1];
         tmp.last_of_run = 1'b1;
         ev[ev.size()-1] = tmp;
      end
      expected_events = {expected_events, ev};
   endfunction

   // predict on every accepted header
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall && !reset;
      if (!reset && req_valid && !req_stall) begin
         track_datagram(req_data);
         headers_taken++;
      end
   end

   // header driver: advance after each transaction, idle in bursts
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (headers_to_send.size() > 0) begin
            req_data <= headers_to_send.pop_front();
            req_valid <= 1'b1;
            headers_sent++;
            if (idle_on && headers_sent < quiet_after && $urandom_range(0, 3) == 0)
               req_gap = $urandom_range(1, 13);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (idle_on && headers_sent < quiet_after && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 13);
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         events_seen++;
         if (rsp_data.event_kind == EV_RESEND) resends_seen++;
         else completes_seen++;
         if (expected_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected event %p", rsp_data);
         end else begin
            want = expected_events.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("event mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   task automatic add_header(int pic, int pkt, int size, int len, int at);
      req_payload_type h;
      h.picture_index  = pic[6:0];
      h.packet_index   = pkt[7:0];
      h.picture_size   = size[15:0];
      h.payload_length = len[11:0];
      h.arrival_time   = at[15:0];
      headers_to_send = {headers_to_send, h};
   endtask

   // one picture sent in random order, some packets lost, late or repeated
   task automatic add_picture(int pic, int size);
      int num, k, a, b, t, len;
      int order[$];
      num = (size + CHUNK - 1) / CHUNK;
      for (k = 0; k < num; k++) order = {order, k};
      for (k = 0; k < num; k++) begin
         a = $urandom_range(0, num - 1);
         b = order[a]; order[a] = order[k]; order[k] = b;
      end
      foreach (order[m]) begin
         len = (order[m] == num - 1) ? size - (num - 1) * CHUNK : CHUNK;
         tick += $urandom_range(0, 12);
         t = $urandom_range(0, 9);
         if (t == 0) continue;
         add_header(pic, order[m], size, len, tick);
         if (t == 1) add_header(pic, order[m], size, len, tick);
      end
      if ($urandom_range(0, 1) == 0) begin
         tick += $urandom_range(0, 40);
         k = $urandom_range(0, num - 1);
         len = (k == num - 1) ? size - (num - 1) * CHUNK : CHUNK;
         add_header(pic, k, size, len, tick);
      end
   endtask

   task automatic drain_and_wait();
      while (headers_to_send.size() > 0 || req_valid || expected_events.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_delays(logic [15:0] lag, logic [15:0] retry);
      logic [15:0] vals[2];
      vals[0] = lag;
      vals[1] = retry;
      for (int k = 0; k < 2; k++) begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= (k == 0) ? REG_REORDER_DELAY : REG_ROUNDTRIP_DELAY;
         csr_wdata <= vals[k];
         do @(posedge clock); while (!csr_ready);
         if (k == 0) lag_limit = lag;
         else retry_limit = retry;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random traffic: mostly whole pictures, some noise
   task automatic add_random_phase(int count);
      int pic, size, start;
      start = headers_to_send.size();
      pic = $urandom_range(0, 99);
      while (headers_to_send.size() - start < count) begin
         case ($urandom_range(0, 9))
            0: add_header($urandom_range(0, 127), $urandom_range(0, 255),
                          $urandom_range(0, 65535), $urandom_range(0, 4095),
                          tick + $urandom_range(0, 65535));
            1: begin
               pic = $urandom_range(0, 99);
               add_picture(pic, $urandom_range(1, 16 * CHUNK));
            end
            default: begin
               pic = (pic + 1) % PIC_WRAP;
               size = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 65535) :
                      $urandom_range(1, 4 * CHUNK);
               if (size > 16 * CHUNK) size = 16 * CHUNK;
               add_picture(pic, size);
            end
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_REORDER_DELAY;
      csr_wdata = '0;
      req_taken = 1'b0;
      req_gap = 0;
      stall_left = 0;
      mismatches = 0;
      headers_sent = 0;
      headers_taken = 0;
      events_seen = 0;
      resends_seen = 0;
      completes_seen = 0;
      quiet_after = 270;
      idle_on = 1'b1;
      tick = 0;
      lag_limit = 16'd10;
      retry_limit = 16'd20;
      hunt_from = 0;
      latest_pic = '0;
      for (int s = 0; s < SLOT_NUM; s++) begin
         pic_busy[s] = 1'b0; pic_id[s] = '0; pic_total[s] = '0;
         pic_got[s] = '0; pic_pkts[s] = 0; pic_top[s] = 0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: rejections, limits, wraps, duplicates and eviction
      add_header(5, 0, 0, 0, 100);
      add_header(5, 0, 5000, 4095, 101);
      add_header(5, 3, 5000, 100, 102);
      add_header(5, 0, 65535, 2914, 103);
      add_header(99, 15, 16 * CHUNK, CHUNK, 110);
      add_header(99, 15, 16 * CHUNK, CHUNK, 111);
      add_header(99, 200, 16 * CHUNK, CHUNK, 112);
      add_header(0, 0, 1, 1, 140);
      add_header(1, 1, 2 * CHUNK, CHUNK, 150);
      add_header(1, 1, 2 * CHUNK, 4095, 151);
      add_header(2, 2, 3 * CHUNK, CHUNK, 160);
      add_header(3, 1, 2 * CHUNK, 10, 170);
      add_header(4, 1, 2 * CHUNK, 10, 180);
      add_header(4, 0, 2 * CHUNK, CHUNK, 65535);
      add_header(3, 0, 2 * CHUNK, CHUNK, 30);
      add_header(60, 0, 2 * CHUNK, CHUNK, 40);
      add_header(2, 0, 3 * CHUNK, CHUNK, 200);
      add_header(2, 1, 3 * CHUNK, CHUNK, 205);
      add_header(127, 255, 65535, 4095, 65535);
      tick = 300;
      drain_and_wait();

      // random phases across delay settings, pausing until idle between them
      add_random_phase(70);
      drain_and_wait();
      write_delays(16'd0, 16'd0);
      add_random_phase(70);
      drain_and_wait();
      write_delays(16'hFFFF, 16'hFFFF);
      add_random_phase(50);
      drain_and_wait();
      write_delays(16'($urandom_range(0, 30)), 16'($urandom_range(0, 60)));
      add_random_phase(90);
      quiet_after = headers_sent + headers_to_send.size() - 40;
      drain_and_wait();

      $display("tb: %0d headers over four delay settings, %0d events (%0d resends, %0d completions)",
               headers_taken, events_seen, resends_seen, completes_seen);
      $display("tb: %0d mismatches, %0d events still awaited", mismatches,
               expected_events.size());
      if (mismatches == 0 && expected_events.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== packet_reassembly_resend_tracker.f =====
src/prrt_pkg.sv
src/prrt_ram.sv
src/prrt_ctrl.sv
src/prrt_datapath.sv
src/packet_reassembly_resend_tracker.sv
sim/tb_top.sv
